// File: sv/abs_pkg.sv
`timescale 1ns / 1ps

package abs_pkg;

    // field widths
    localparam int TIME_W   = 48;
    localparam int BYTES_W  = 31;
    localparam int WEIGHT_W = 17;
    localparam int RATE_W   = 20;
    localparam int BPS_W    = 40;
    localparam int FRAC_W   = 16;
    localparam int EST_W    = 56;

    // table slots held in registers; the search covers min(levels, slots)
    localparam int LEVEL_SLOTS      = 4;
    localparam int RATE_LEVELS_DEF  = 4;

    // decoupling queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 20;

    localparam logic [CFG_INDEX_W-1:0] CFG_WEIGHT     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_LEVEL_0    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_LEVEL_1    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_LEVEL_2    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_LEVEL_3    = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_START_RATE = 3'd5;

    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE   = 17'h10000;
    localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 17'h08000;

    localparam logic [LEVEL_SLOTS-1:0][RATE_W-1:0] LEVEL_RESET =
        {20'd2000, 20'd1000, 20'd500, 20'd100};
    localparam logic [RATE_W-1:0] START_RATE_RESET = 20'd100;

    // arithmetic constants
    localparam logic [TIME_W-1:0] MIN_ELAPSED  = 48'd10;
    localparam logic [12:0]       SAMPLE_SCALE = 13'd8000;
    localparam logic [10:0]       UP_SCALE     = 11'd1500;
    localparam logic [9:0]        DOWN_SCALE   = 10'd1000;

    typedef struct packed {
        logic [WEIGHT_W-1:0]                   weight;
        logic [LEVEL_SLOTS-1:0][RATE_W-1:0]    levels;
    } abs_cfg_t;

    typedef struct packed {
        logic                 timing_error;
        logic [TIME_W-1:0]    elapsed;
        logic [BYTES_W-1:0]   bytes;
    } abs_item_t;

endpackage

// File: sv/abs_front.sv
`timescale 1ns / 1ps

module abs_front
(
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [abs_pkg::TIME_W-1:0]    start_ms,
    input  logic [abs_pkg::TIME_W-1:0]    end_ms,
    input  logic [abs_pkg::BYTES_W-1:0]   chunk_bytes,
    input  logic                          q_full,
    output logic                          q_push,
    output abs_pkg::abs_item_t            q_item
);

    logic [abs_pkg::TIME_W-1:0] elapsed;

    assign elapsed = end_ms - start_ms;

    // short or reversed transfers are flagged here and skip the divide
    assign q_item.timing_error = (end_ms <= start_ms) || (elapsed <= abs_pkg::MIN_ELAPSED);
    assign q_item.elapsed      = elapsed;
    assign q_item.bytes        = chunk_bytes;

    assign in_stall = q_full;
    assign q_push   = in_valid && !q_full;

endmodule

// File: sv/abs_queue.sv
`timescale 1ns / 1ps

module abs_queue
#(
    parameter int DEPTH = abs_pkg::QUEUE_DEPTH
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  abs_pkg::abs_item_t    push_item,
    output logic                  full,
    input  logic                  pop,
    output logic                  empty,
    output abs_pkg::abs_item_t    head_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    abs_pkg::abs_item_t mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               do_push;
    logic               do_pop;

    assign full      = (count_reg == FULL_CNT);
    assign empty     = (count_reg == '0);
    assign head_item = mem_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && !empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// File: sv/abs_back.sv
`timescale 1ns / 1ps

module abs_back
#(
    parameter int RATE_LEVELS = abs_pkg::RATE_LEVELS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  abs_pkg::abs_cfg_t             cfg,
    input  logic                          q_empty,
    input  abs_pkg::abs_item_t            q_head,
    output logic                          q_pop,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          timing_error,
    output logic [abs_pkg::BPS_W-1:0]     sample_rate_bps,
    output logic [abs_pkg::BPS_W-1:0]     estimate_bps,
    output logic [abs_pkg::RATE_W-1:0]    chosen_rate
);

    localparam int LEVEL_COUNT = (RATE_LEVELS < abs_pkg::LEVEL_SLOTS) ?
                                 RATE_LEVELS : abs_pkg::LEVEL_SLOTS;
    localparam int STEP_W   = $clog2(abs_pkg::BYTES_W);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(abs_pkg::BYTES_W - 1);
    localparam int SCALED_W = abs_pkg::BYTES_W + 13;
    localparam int PROD_W   = abs_pkg::EST_W + 1;
    localparam int FRAC_P_W = abs_pkg::WEIGHT_W + abs_pkg::FRAC_W;
    localparam int UP_THR_W = abs_pkg::RATE_W + 11;
    localparam int DN_THR_W = abs_pkg::RATE_W + 10;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_DIV    = 3'd1;
    localparam logic [2:0] ST_SAMPLE = 3'd2;
    localparam logic [2:0] ST_PROD   = 3'd3;
    localparam logic [2:0] ST_SUM    = 3'd4;
    localparam logic [2:0] ST_CMP    = 3'd5;
    localparam logic [2:0] ST_DONE   = 3'd6;

    logic [2:0]                    state_reg;
    logic [2:0]                    state_next;
    logic [STEP_W-1:0]             step_reg;
    logic                          err_reg;
    logic [abs_pkg::TIME_W-1:0]    divisor_reg;
    logic [abs_pkg::BYTES_W-1:0]   quo_reg;
    logic [abs_pkg::BYTES_W-1:0]   rem_reg;
    logic [abs_pkg::BPS_W-1:0]     sample_reg;
    logic [PROD_W-1:0]             prod_new_reg;
    logic [PROD_W-1:0]             prod_old_reg;
    logic [abs_pkg::WEIGHT_W-1:0]  prod_frac_reg;
    logic [abs_pkg::RATE_W-1:0]    up_reg;
    logic [abs_pkg::RATE_W-1:0]    down_reg;
    logic [UP_THR_W-1:0]           up_thr_reg;
    logic [DN_THR_W-1:0]           dn_old_thr_reg;
    logic [DN_THR_W-1:0]           dn_up_thr_reg;
    logic [abs_pkg::EST_W-1:0]     est_reg;
    logic [abs_pkg::RATE_W-1:0]    rate_reg;
    logic                          out_valid_reg;
    logic                          out_err_reg;
    logic [abs_pkg::BPS_W-1:0]     out_sample_reg;
    logic [abs_pkg::BPS_W-1:0]     out_est_reg;
    logic [abs_pkg::RATE_W-1:0]    out_rate_reg;

    logic [abs_pkg::BYTES_W:0]     trial;
    logic [abs_pkg::BYTES_W:0]     trial_diff;
    logic                          trial_fits;
    logic [SCALED_W-1:0]           scaled;
    logic [abs_pkg::BPS_W-1:0]     sample_sat;
    logic [abs_pkg::WEIGHT_W-1:0]  w_eff;
    logic [abs_pkg::WEIGHT_W-1:0]  keep;
    logic [FRAC_P_W-1:0]           frac_prod;
    logic [PROD_W-1:0]             est_sum;
    logic [abs_pkg::RATE_W-1:0]    up_sel;
    logic [abs_pkg::RATE_W-1:0]    down_sel;
    logic                          hit_up;
    logic                          low_old;
    logic                          low_up;
    logic                          go_down;
    logic [abs_pkg::RATE_W-1:0]    rate_after_up;
    logic                          out_free;

    // restoring divide, one quotient bit per cycle
    assign trial      = {rem_reg, quo_reg[abs_pkg::BYTES_W-1]};
    assign trial_fits = {{(abs_pkg::TIME_W - abs_pkg::BYTES_W - 1){1'b0}}, trial} >= divisor_reg;
    assign trial_diff = trial - divisor_reg[abs_pkg::BYTES_W:0];

    // bytes per ms times 8000, clamped to 40 bits
    assign scaled     = SCALED_W'(quo_reg) * SCALED_W'(abs_pkg::SAMPLE_SCALE);
    assign sample_sat = (|scaled[SCALED_W-1:abs_pkg::BPS_W]) ? '1 : scaled[abs_pkg::BPS_W-1:0];

    assign w_eff     = (cfg.weight > abs_pkg::WEIGHT_ONE) ? abs_pkg::WEIGHT_ONE : cfg.weight;
    assign keep      = abs_pkg::WEIGHT_ONE - w_eff;
    assign frac_prod = FRAC_P_W'(keep) * FRAC_P_W'(est_reg[abs_pkg::FRAC_W-1:0]);
    assign est_sum   = prod_new_reg + prod_old_reg + PROD_W'(prod_frac_reg);

    // neighbor levels of the held rate: lowest above, highest below
    always_comb
    begin
        up_sel   = rate_reg;
        down_sel = rate_reg;
        for (int i = LEVEL_COUNT - 1; i >= 0; i--)
        begin
            if (cfg.levels[i] > rate_reg)
            begin
                up_sel = cfg.levels[i];
            end
        end
        for (int i = 0; i < LEVEL_COUNT; i++)
        begin
            if (cfg.levels[i] < rate_reg)
            begin
                down_sel = cfg.levels[i];
            end
        end
    end

    // all three compares in parallel, the down test picks the one for the post-up rate
    assign hit_up  = est_reg > {9'b0, up_thr_reg, {abs_pkg::FRAC_W{1'b0}}};
    assign low_old = est_reg < {10'b0, dn_old_thr_reg, {abs_pkg::FRAC_W{1'b0}}};
    assign low_up  = est_reg < {10'b0, dn_up_thr_reg, {abs_pkg::FRAC_W{1'b0}}};
    assign go_down = hit_up ? low_up : low_old;
    assign rate_after_up = hit_up ? up_reg : rate_reg;

    assign out_free = !out_valid_reg || !out_stall;
    assign q_pop    = (state_reg == ST_IDLE) && !q_empty;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    state_next = q_head.timing_error ? ST_DONE : ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (step_reg == LAST_STEP)
                begin
                    state_next = ST_SAMPLE;
                end
            end
            ST_SAMPLE: state_next = ST_PROD;
            ST_PROD:   state_next = ST_SUM;
            ST_SUM:    state_next = ST_CMP;
            ST_CMP:    state_next = ST_DONE;
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            est_reg       <= '0;
            rate_reg      <= abs_pkg::START_RATE_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_SUM)
            begin
                est_reg <= est_sum[abs_pkg::EST_W-1:0];
            end
            if (state_reg == ST_CMP)
            begin
                rate_reg <= go_down ? down_reg : rate_after_up;
            end
            if (state_reg == ST_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            err_reg     <= q_head.timing_error;
            divisor_reg <= q_head.elapsed;
            quo_reg     <= q_head.bytes;
            rem_reg     <= '0;
            step_reg    <= '0;
        end
        if (state_reg == ST_DIV)
        begin
            rem_reg  <= trial_fits ? trial_diff[abs_pkg::BYTES_W-1:0]
                                   : trial[abs_pkg::BYTES_W-1:0];
            quo_reg  <= {quo_reg[abs_pkg::BYTES_W-2:0], trial_fits};
            step_reg <= step_reg + 1'b1;
        end
        if (state_reg == ST_SAMPLE)
        begin
            sample_reg <= sample_sat;
            up_reg     <= up_sel;
            down_reg   <= down_sel;
        end
        if (state_reg == ST_PROD)
        begin
            prod_new_reg   <= PROD_W'(w_eff) * PROD_W'(sample_reg);
            prod_old_reg   <= PROD_W'(keep) * PROD_W'(est_reg[abs_pkg::EST_W-1:abs_pkg::FRAC_W]);
            prod_frac_reg  <= frac_prod[FRAC_P_W-1:abs_pkg::FRAC_W];
            up_thr_reg     <= UP_THR_W'(up_reg) * UP_THR_W'(abs_pkg::UP_SCALE);
            dn_old_thr_reg <= DN_THR_W'(rate_reg) * DN_THR_W'(abs_pkg::DOWN_SCALE);
            dn_up_thr_reg  <= DN_THR_W'(up_reg) * DN_THR_W'(abs_pkg::DOWN_SCALE);
        end
        if (state_reg == ST_DONE && out_free)
        begin
            out_err_reg    <= err_reg;
            out_sample_reg <= err_reg ? '0 : sample_reg;
            out_est_reg    <= est_reg[abs_pkg::EST_W-1:abs_pkg::FRAC_W];
            out_rate_reg   <= rate_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign timing_error    = out_err_reg;
    assign sample_rate_bps = out_sample_reg;
    assign estimate_bps    = out_est_reg;
    assign chosen_rate     = out_rate_reg;

endmodule

// File: sv/adaptive_bitrate_selector_unit.sv
`timescale 1ns / 1ps

// adaptive bitrate selector: one finished chunk transfer in, one result out
// input channel in_valid/in_stall carries start_ms, end_ms and chunk_bytes;
// output channel out_valid/out_stall carries timing_error, sample_rate_bps,
// estimate_bps and chosen_rate; cfg_write/cfg_index/cfg_data load the weight
// and the four-entry rate table; the user must load them only while no item is
// in flight, the block does not enforce it; front classifies the transfer time
// and drops the item into a two-entry queue, back runs a restoring divide of
// bytes by elapsed ms, then scales, folds the sample into the q40.16 moving
// average and steps the rate
// the back end takes a new item only once done with the last, so the serial
// divider bounds throughput; flagged items skip the divide in the back end
// the queue takes up to two items ahead while the back end is busy
// a stalled result holds in the output register; the back end then waits with
// its next result finished, and the queue fills until in_stall rises
// reset clears the estimate, loads the rate with 100 kbit/s, restores the
// register reset values and empties queue and output register
module adaptive_bitrate_selector_unit
#(
    parameter int RATE_LEVELS = abs_pkg::RATE_LEVELS_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    // chunk channel
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [abs_pkg::TIME_W-1:0]        start_ms,
    input  logic [abs_pkg::TIME_W-1:0]        end_ms,
    input  logic [abs_pkg::BYTES_W-1:0]       chunk_bytes,
    // result channel
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              timing_error,
    output logic [abs_pkg::BPS_W-1:0]         sample_rate_bps,
    output logic [abs_pkg::BPS_W-1:0]         estimate_bps,
    output logic [abs_pkg::RATE_W-1:0]        chosen_rate,
    // register write port
    input  logic                              cfg_write,
    input  logic [abs_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [abs_pkg::CFG_DATA_W-1:0]    cfg_data
);

    abs_pkg::abs_cfg_t  cfg_reg;
    abs_pkg::abs_item_t push_item;
    abs_pkg::abs_item_t head_item;
    logic               q_full;
    logic               q_empty;
    logic               q_push;
    logic               q_pop;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.weight <= abs_pkg::WEIGHT_RESET;
            cfg_reg.levels <= abs_pkg::LEVEL_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                abs_pkg::CFG_WEIGHT:  cfg_reg.weight    <= cfg_data[abs_pkg::WEIGHT_W-1:0];
                abs_pkg::CFG_LEVEL_0: cfg_reg.levels[0] <= cfg_data;
                abs_pkg::CFG_LEVEL_1: cfg_reg.levels[1] <= cfg_data;
                abs_pkg::CFG_LEVEL_2: cfg_reg.levels[2] <= cfg_data;
                abs_pkg::CFG_LEVEL_3: cfg_reg.levels[3] <= cfg_data;
                // start rate only acts at reset, where it holds its reset value
                abs_pkg::CFG_START_RATE: ;
                default: ;
            endcase
        end
    end

    abs_front u_front
    (
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .start_ms    (start_ms),
        .end_ms      (end_ms),
        .chunk_bytes (chunk_bytes),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_item      (push_item)
    );

    abs_queue #(.DEPTH(abs_pkg::QUEUE_DEPTH)) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .head_item (head_item)
    );

    abs_back #(.RATE_LEVELS(RATE_LEVELS)) u_back
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg_reg),
        .q_empty         (q_empty),
        .q_head          (head_item),
        .q_pop           (q_pop),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .timing_error    (timing_error),
        .sample_rate_bps (sample_rate_bps),
        .estimate_bps    (estimate_bps),
        .chosen_rate     (chosen_rate)
    );

endmodule
